[design/ctft_pkg.sv]
// ----------------------------------------------------------------------------
// ctft_pkg
// Shared types, codes and constants of the complementary tilt filter.
// ----------------------------------------------------------------------------
package ctft_pkg;

   localparam int ATAN_LEN = 24;
   localparam int CNT_W    = 5;
   localparam int DIV_QB   = 18;
   localparam int DIV_CORR = 3;

   localparam logic signed [18:0] RATE_K       = 19'sd256250;
   localparam logic signed [32:0] QUARTER_TURN = 33'sd377487360;
   localparam logic signed [32:0] ROUND_HALF   = 33'sd32768;
   localparam logic signed [32:0] ANGLE_MAX    = 33'sd11520;
   localparam logic signed [32:0] ANGLE_MIN    = -33'sd11520;
   localparam logic [16:0]        Q16_ONE      = 17'd65536;
   localparam logic [16:0]        WEIGHT_RESET = 17'd52429;

   localparam logic [55:0] DIV_DEN  = 56'd16793600000;
   localparam logic [55:0] DIV_HALF = 56'd8396800000;
   localparam logic [55:0] DIV_OFF  = DIV_DEN << (DIV_QB - 1);
   localparam logic signed [18:0] Q_OFF = 19'sd131072;

   // divisor after the 2^17 shift, and floor(2^35 / DIV_K)
   localparam logic [16:0] DIV_K     = 17'd128125;
   localparam logic [18:0] DIV_RECIP = 19'd268173;

   localparam logic [1:0] REG_BIAS_X = 2'd0;
   localparam logic [1:0] REG_BIAS_Y = 2'd1;
   localparam logic [1:0] REG_BIAS_Z = 2'd2;
   localparam logic [1:0] REG_WEIGHT = 2'd3;

   localparam logic [1:0] SEL_PITCH = 2'd0;
   localparam logic [1:0] SEL_ROLL  = 2'd1;
   localparam logic [1:0] SEL_YAW   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CINIT, ST_CITER, ST_ROUND, ST_MUL1, ST_MUL2,
      ST_DINIT, ST_DEST, ST_DREM, ST_DITER, ST_COMMIT, ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_CINIT, OP_CITER, OP_ROUND, OP_MUL1, OP_MUL2,
      OP_DINIT, OP_DEST, OP_DREM, OP_DITER, OP_COMMIT, OP_OUT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [1:0]       sel;
      logic [CNT_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   // atan(2^-i) in 2^-22 degree
   function automatic logic [27:0] atan_units(input logic [CNT_W-1:0] i);
      logic [27:0] v;
      unique case (i)
         5'd0:  v = 28'd188743680;
         5'd1:  v = 28'd111421900;
         5'd2:  v = 28'd58872272;
         5'd3:  v = 28'd29884485;
         5'd4:  v = 28'd15000234;
         5'd5:  v = 28'd7507429;
         5'd6:  v = 28'd3754631;
         5'd7:  v = 28'd1877430;
         5'd8:  v = 28'd938729;
         5'd9:  v = 28'd469366;
         5'd10: v = 28'd234683;
         5'd11: v = 28'd117342;
         5'd12: v = 28'd58671;
         5'd13: v = 28'd29335;
         5'd14: v = 28'd14668;
         5'd15: v = 28'd7334;
         5'd16: v = 28'd3667;
         5'd17: v = 28'd1833;
         5'd18: v = 28'd917;
         5'd19: v = 28'd458;
         5'd20: v = 28'd229;
         5'd21: v = 28'd115;
         5'd22: v = 28'd57;
         5'd23: v = 28'd29;
         default: v = 28'd0;
      endcase
      return v;
   endfunction

endpackage

[design/ctft_ctrl.sv]
// ----------------------------------------------------------------------------
// ctft_ctrl
// Sequencer: CORDIC iterations, blend products and divide for each angle.
// ----------------------------------------------------------------------------
module ctft_ctrl #(
   parameter int STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ctft_pkg::status_type status,
   output ctft_pkg::cmd_type    cmd
);

   localparam int STEPS_EFF = (STEPS > ctft_pkg::ATAN_LEN) ? ctft_pkg::ATAN_LEN : STEPS;
   localparam logic [ctft_pkg::CNT_W-1:0] C_LAST = ctft_pkg::CNT_W'(STEPS_EFF - 1);
   localparam logic [ctft_pkg::CNT_W-1:0] D_FIRST = ctft_pkg::CNT_W'(ctft_pkg::DIV_CORR - 1);

   ctft_pkg::state_type            state_ff, state_in;
   logic [ctft_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]                     sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctft_pkg::ST_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         ctft_pkg::ST_IDLE: begin
            sel_in = ctft_pkg::SEL_PITCH;
            if (req_tvalid) state_in = ctft_pkg::ST_CINIT;
         end
         ctft_pkg::ST_CINIT: begin
            cnt_in   = '0;
            state_in = ctft_pkg::ST_CITER;
         end
         ctft_pkg::ST_CITER: begin
            if (cnt_ff == C_LAST) state_in = ctft_pkg::ST_ROUND;
            else cnt_in = cnt_ff + 1'b1;
         end
         ctft_pkg::ST_ROUND: state_in = ctft_pkg::ST_MUL1;
         ctft_pkg::ST_MUL1:  state_in = ctft_pkg::ST_MUL2;
         ctft_pkg::ST_MUL2:  state_in = ctft_pkg::ST_DINIT;
         ctft_pkg::ST_DINIT: state_in = ctft_pkg::ST_DEST;
         ctft_pkg::ST_DEST:  state_in = ctft_pkg::ST_DREM;
         ctft_pkg::ST_DREM: begin
            cnt_in   = D_FIRST;
            state_in = ctft_pkg::ST_DITER;
         end
         ctft_pkg::ST_DITER: begin
            if (cnt_ff == '0) state_in = ctft_pkg::ST_COMMIT;
            else cnt_in = cnt_ff - 1'b1;
         end
         ctft_pkg::ST_COMMIT: begin
            if (sel_ff == ctft_pkg::SEL_YAW) begin
               state_in = ctft_pkg::ST_FINISH;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ctft_pkg::ST_CINIT;
            end
         end
         ctft_pkg::ST_FINISH: begin
            if (!status.out_busy) state_in = ctft_pkg::ST_IDLE;
         end
         default: state_in = ctft_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.op     = ctft_pkg::OP_NONE;
      cmd.sel    = sel_ff;
      cmd.idx    = cnt_ff;
      unique case (state_ff)
         ctft_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = ctft_pkg::OP_LOAD;
         end
         ctft_pkg::ST_CINIT:  cmd.op = ctft_pkg::OP_CINIT;
         ctft_pkg::ST_CITER:  cmd.op = ctft_pkg::OP_CITER;
         ctft_pkg::ST_ROUND:  cmd.op = ctft_pkg::OP_ROUND;
         ctft_pkg::ST_MUL1:   cmd.op = ctft_pkg::OP_MUL1;
         ctft_pkg::ST_MUL2:   cmd.op = ctft_pkg::OP_MUL2;
         ctft_pkg::ST_DINIT:  cmd.op = ctft_pkg::OP_DINIT;
         ctft_pkg::ST_DEST:   cmd.op = ctft_pkg::OP_DEST;
         ctft_pkg::ST_DREM:   cmd.op = ctft_pkg::OP_DREM;
         ctft_pkg::ST_DITER:  cmd.op = ctft_pkg::OP_DITER;
         ctft_pkg::ST_COMMIT: cmd.op = ctft_pkg::OP_COMMIT;
         ctft_pkg::ST_FINISH: begin
            if (!status.out_busy) cmd.op = ctft_pkg::OP_OUT;
         end
         default: cmd.op = ctft_pkg::OP_NONE;
      endcase
   end

endmodule

[design/ctft_datapath.sv]
// ----------------------------------------------------------------------------
// ctft_datapath
// Shared CORDIC, blend multipliers, reciprocal divider, estimates, output reg.
// ----------------------------------------------------------------------------
module ctft_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ctft_pkg::cmd_type     cmd,
   output ctft_pkg::status_type  status,
   input  logic [111:0]          req_tdata,
   input  logic [15:0]           bias_x,
   input  logic [15:0]           bias_y,
   input  logic [15:0]           bias_z,
   input  logic [16:0]           weight,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [143:0]          rsp_tdata
);

   logic signed [15:0] ax_ff, ay_ff, az_ff, cx_ff, cy_ff, cz_ff;
   logic [15:0]        dt_ff;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic               zero_ff, zero_in;
   logic signed [14:0] ang_ff [3];
   logic signed [15:0] est_ff [3];
   logic signed [34:0] p1_ff, p3_ff;
   logic signed [33:0] p2_ff;
   logic signed [55:0] m1_ff, m2_ff;
   logic [34:0]        n_ff, n_in;
   logic [34:0]        rem_ff, rem_in;
   logic [ctft_pkg::DIV_QB-1:0] q_ff, q_in;
   logic               out_valid_ff;
   logic [143:0]       out_ff;

   logic signed [15:0] num, den, est_sel, rate_sel;
   logic signed [33:0] xi, yi, xs, ys;
   logic signed [32:0] zr, at;
   logic signed [14:0] ang_in, ang_sel;
   logic [16:0]        a_eff, wa;
   logic signed [34:0] p1_in, p3_in;
   logic signed [33:0] p2_in;
   logic signed [55:0] s_w, m1_in, m2_in, num_s;
   logic [36:0]        q_est;
   logic [34:0]        q_mul;
   logic signed [18:0] qv;
   logic signed [15:0] est_in;

   assign a_eff = (weight > ctft_pkg::Q16_ONE) ? ctft_pkg::Q16_ONE : weight;
   assign wa    = ctft_pkg::Q16_ONE - a_eff;

   always_comb begin
      unique case (cmd.sel)
         ctft_pkg::SEL_PITCH: begin num = ay_ff; den = az_ff; rate_sel = cx_ff; end
         ctft_pkg::SEL_ROLL:  begin num = ax_ff; den = az_ff; rate_sel = cy_ff; end
         default:             begin num = ax_ff; den = ay_ff; rate_sel = cz_ff; end
      endcase
   end
   assign est_sel = est_ff[cmd.sel];
   assign ang_sel = ang_ff[cmd.sel];

   // CORDIC vectoring
   assign xi = {{4{den[15]}}, den, 14'd0};
   assign yi = {{4{num[15]}}, num, 14'd0};
   assign xs = x_ff >>> cmd.idx;
   assign ys = y_ff >>> cmd.idx;
   assign at = 33'(ctft_pkg::atan_units(cmd.idx));
   assign zr = (z_ff + ctft_pkg::ROUND_HALF) >>> 16;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      if (cmd.op == ctft_pkg::OP_CINIT) begin
         zero_in = (num == 16'sd0) && (den == 16'sd0);
         if (!den[15]) begin
            x_in = xi; y_in = yi; z_in = '0;
         end else if (!num[15]) begin
            x_in = yi; y_in = -xi; z_in = ctft_pkg::QUARTER_TURN;
         end else begin
            x_in = -yi; y_in = xi; z_in = -ctft_pkg::QUARTER_TURN;
         end
      end else if (cmd.op == ctft_pkg::OP_CITER) begin
         if (!y_ff[33]) begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
         end
      end
   end

   always_comb begin
      if (zero_ff) ang_in = '0;
      else if (zr > ctft_pkg::ANGLE_MAX) ang_in = 15'(ctft_pkg::ANGLE_MAX);
      else if (zr < ctft_pkg::ANGLE_MIN) ang_in = 15'(ctft_pkg::ANGLE_MIN);
      else ang_in = 15'(zr);
   end

   // blend products
   assign p1_in = 35'(est_sel) * 35'(ctft_pkg::RATE_K);
   assign p2_in = 34'(rate_sel) * $signed({18'd0, dt_ff});
   assign p3_in = 35'(ang_sel) * 35'(ctft_pkg::RATE_K);
   assign s_w   = 56'(p1_ff) + 56'(p2_ff);
   assign m1_in = s_w * $signed({39'd0, a_eff});
   assign m2_in = 56'(p3_ff) * $signed({39'd0, wa});
   assign num_s = m1_ff + m2_ff + $signed(ctft_pkg::DIV_HALF) + $signed(ctft_pkg::DIV_OFF);

   // divide: shift by 2^17, reciprocal estimate from the top bits, then
   // remainder and a few compare-and-subtract corrections
   assign q_est = {19'd0, n_ff[34:17]} * {18'd0, ctft_pkg::DIV_RECIP};
   assign q_mul = {17'd0, q_ff} * {18'd0, ctft_pkg::DIV_K};
   always_comb begin
      n_in   = n_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      if (cmd.op == ctft_pkg::OP_DINIT) begin
         n_in = num_s[51:17];
      end else if (cmd.op == ctft_pkg::OP_DEST) begin
         q_in = q_est[35:18];
      end else if (cmd.op == ctft_pkg::OP_DREM) begin
         rem_in = n_ff - q_mul;
      end else if (cmd.op == ctft_pkg::OP_DITER && rem_ff >= {18'd0, ctft_pkg::DIV_K}) begin
         rem_in = rem_ff - {18'd0, ctft_pkg::DIV_K};
         q_in   = q_ff + 1'b1;
      end
   end

   assign qv = $signed({1'b0, q_ff}) - ctft_pkg::Q_OFF;
   always_comb begin
      if (qv > 19'sd32767) est_in = 16'sd32767;
      else if (qv < -19'sd32768) est_in = -16'sd32768;
      else est_in = 16'(qv);
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      if (cmd.op == ctft_pkg::OP_LOAD) begin
         ax_ff <= req_tdata[15:0];
         ay_ff <= req_tdata[31:16];
         az_ff <= req_tdata[47:32];
         cx_ff <= req_tdata[63:48] - bias_x;
         cy_ff <= req_tdata[79:64] - bias_y;
         cz_ff <= req_tdata[95:80] - bias_z;
         dt_ff <= req_tdata[111:96];
      end
      if (cmd.op == ctft_pkg::OP_ROUND) ang_ff[cmd.sel] <= ang_in;
      if (cmd.op == ctft_pkg::OP_MUL1) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
      end
      if (cmd.op == ctft_pkg::OP_MUL2) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
      if (cmd.op == ctft_pkg::OP_OUT) begin
         out_ff <= {3'd0, cz_ff, cy_ff, cx_ff, est_ff[2], est_ff[1], est_ff[0],
                    ang_ff[2], ang_ff[1], ang_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff[0]    <= '0;
         est_ff[1]    <= '0;
         est_ff[2]    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == ctft_pkg::OP_COMMIT) est_ff[cmd.sel] <= est_in;
         if (cmd.op == ctft_pkg::OP_OUT) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   assign status.out_busy = out_valid_ff && !rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_ff;

endmodule

[design/imu_complementary_tilt_filter_top.sv]
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_top
// Complementary tilt filter: accelerometer angles blended with gyro rates.
// ----------------------------------------------------------------------------
// req_* carries one raw IMU sample per transaction; rsp_* returns one result
// transaction per sample: three accelerometer angles, three filtered angles
// and three bias-corrected gyro rates. csr_* is an APB-style register port
// for the gyro biases and the blend weight; write it only while idle.
// Each sample runs its three angles one after another through one shared
// unit: CORDIC_STEPS (max 24) vectoring iterations, setup and multiply
// steps, a reciprocal divide with remainder correction, plus one commit.
// The controller returns to idle when the result is loaded into the output
// register and can then accept a new sample. The output register holds a
// result while rsp_tready is low; the next sample may be accepted and
// worked on meanwhile, finishing only once the held result is taken.
// Reset clears the estimates, sets biases to zero and the weight to 52429.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, interval_us
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tilt_pitch_acc, tilt_roll_acc, heading_acc, blended_pitch, blended_roll,
   // blended_yaw, rate_x_corrected, rate_y_corrected, rate_z_corrected
   output logic [143:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [15:0] bias_x_ff, bias_y_ff, bias_z_ff;
   logic [16:0] weight_ff;
   logic        wr_en;
   ctft_pkg::cmd_type    cmd;
   ctft_pkg::status_type status;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_x_ff <= '0;
         bias_y_ff <= '0;
         bias_z_ff <= '0;
         weight_ff <= ctft_pkg::WEIGHT_RESET;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            ctft_pkg::REG_BIAS_X: bias_x_ff <= csr_pwdata[15:0];
            ctft_pkg::REG_BIAS_Y: bias_y_ff <= csr_pwdata[15:0];
            ctft_pkg::REG_BIAS_Z: bias_z_ff <= csr_pwdata[15:0];
            default:              weight_ff <= csr_pwdata[16:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         ctft_pkg::REG_BIAS_X: csr_prdata = {16'd0, bias_x_ff};
         ctft_pkg::REG_BIAS_Y: csr_prdata = {16'd0, bias_y_ff};
         ctft_pkg::REG_BIAS_Z: csr_prdata = {16'd0, bias_z_ff};
         default:              csr_prdata = {15'd0, weight_ff};
      endcase
   end

   ctft_ctrl #(.STEPS(CORDIC_STEPS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ctft_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .bias_x     (bias_x_ff),
      .bias_y     (bias_y_ff),
      .bias_z     (bias_z_ff),
      .weight     (weight_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a transaction is in progress");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[14:0]) <= 15'sd11520 &&
                      $signed(rsp_tdata[14:0]) >= -15'sd11520))
      else $error("accelerometer pitch out of range");

endmodule
